/* design/ghsa_pkg.sv */
// Shared types, codes and arithmetic helpers for the Gaussian HMM statistics accumulator.
package ghsa_pkg;

    localparam int DEF_MAX_STATES   = 16;
    localparam int DEF_MAX_FEATURES = 16;

    localparam int STAT_W = 64;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int POST_W = 16;
    localparam int ACT_W  = 3;
    localparam int OP_W   = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [CFG_W-1:0] CFG_RESET_USED = CFG_W'(16);

    // register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_FEATURES_USED = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_STATES_USED   = 1'b1;

    // input actions
    localparam logic [ACT_W-1:0] ACT_LOAD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACCUM    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RD_TOTAL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_SUM   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RD_SQ    = 3'd4;

    // operations carried along the cell chain
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_ACC    = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_SUM = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_SQ  = 3'd4;

    localparam logic signed [STAT_W-1:0] STAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [STAT_W-1:0] STAT_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        feature_index;
        logic [IDX_W-1:0]        state_index;
        logic signed [VAL_W-1:0] feature_value;
        logic [POST_W-1:0]       posterior;
    } in_t;

    typedef struct packed {
        logic signed [STAT_W-1:0] stat_value;
        logic                     index_error;
    } out_t;

    // token handed from cell to cell
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        state;
        logic [IDX_W-1:0]        feat;
        logic signed [VAL_W-1:0] value;
        logic [POST_W-1:0]       post;
    } tok_t;

    // result bus, following the token in the next cycle
    typedef struct packed {
        logic                     vld;
        logic signed [STAT_W-1:0] value;
    } res_t;

    function automatic logic signed [STAT_W-1:0] sat_add(
        input logic signed [STAT_W-1:0] a,
        input logic signed [STAT_W-1:0] b
    );
        logic signed [STAT_W-1:0] s;
        s = a + b;
        if (a[STAT_W-1] == b[STAT_W-1] && s[STAT_W-1] != a[STAT_W-1])
        begin
            sat_add = a[STAT_W-1] ? STAT_MIN : STAT_MAX;
        end
        else
        begin
            sat_add = s;
        end
    endfunction

endpackage

/* design/ghsa_cell.sv */
// One feature cell: frame value, per-state sum and square-sum stores, chain stage.
module ghsa_cell #(
    parameter int IDX        = 0,
    parameter int MAX_STATES = ghsa_pkg::DEF_MAX_STATES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ghsa_pkg::CFG_W-1:0]    features_used,
    input  ghsa_pkg::tok_t                tok_in,
    output ghsa_pkg::tok_t                tok_out,
    input  ghsa_pkg::res_t                res_in,
    output ghsa_pkg::res_t                res_out
);

    localparam int ST_AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int PX_W  = ghsa_pkg::POST_W + ghsa_pkg::VAL_W + 1;
    localparam int PXX_W = PX_W + ghsa_pkg::VAL_W;

    logic signed [ghsa_pkg::VAL_W-1:0]  x_reg;
    logic signed [ghsa_pkg::VAL_W-1:0]  x_next;
    ghsa_pkg::tok_t                     tok1_reg;
    ghsa_pkg::tok_t                     tok2_reg;
    ghsa_pkg::res_t                     res_reg;
    ghsa_pkg::res_t                     res_next;
    logic [MAX_STATES-1:0]              valid_reg;

    logic signed [ghsa_pkg::STAT_W-1:0] sum_mem [MAX_STATES];
    logic signed [ghsa_pkg::STAT_W-1:0] sq_mem  [MAX_STATES];
    logic signed [ghsa_pkg::STAT_W-1:0] sum_rd_reg;
    logic signed [ghsa_pkg::STAT_W-1:0] sq_rd_reg;
    logic                               vld1_reg;
    logic signed [ghsa_pkg::STAT_W-1:0] sum2_reg;
    logic signed [ghsa_pkg::STAT_W-1:0] sq2_reg;
    logic signed [PX_W-1:0]             px1_reg;
    logic signed [PX_W-1:0]             px2_reg;
    logic signed [PXX_W-1:0]            pxx2_reg;

    logic signed [PX_W-1:0]             px;
    logic signed [PXX_W-1:0]            pxx;
    logic                               in_use;
    logic                               wr_en;
    logic [ST_AW-1:0]                   rd_addr;
    logic [ST_AW-1:0]                   wr_addr;
    logic signed [ghsa_pkg::STAT_W-1:0] sum_new;
    logic signed [ghsa_pkg::STAT_W-1:0] sq_new;

    assign in_use  = IDX < int'(features_used);
    assign rd_addr = ST_AW'(tok_in.state);
    assign wr_addr = ST_AW'(tok2_reg.state);
    assign wr_en   = (tok2_reg.op == ghsa_pkg::OP_ACC) && in_use;

    // posterior is an unsigned fraction: widen with a zero sign bit
    assign px  = $signed({1'b0, tok_in.post}) * x_reg;
    assign pxx = px1_reg * x_reg;

    assign sum_new = ghsa_pkg::sat_add(sum2_reg, ghsa_pkg::STAT_W'(px2_reg));
    assign sq_new  = ghsa_pkg::sat_add(sq2_reg, ghsa_pkg::STAT_W'(pxx2_reg));

    always_comb
    begin
        x_next = x_reg;
        if (tok_in.op == ghsa_pkg::OP_LOAD && int'(tok_in.feat) == IDX)
        begin
            x_next = tok_in.value;
        end
    end

    // the matching cell drops its entry onto the result bus
    always_comb
    begin
        res_next = res_in;
        if ((tok1_reg.op == ghsa_pkg::OP_RD_SUM || tok1_reg.op == ghsa_pkg::OP_RD_SQ)
            && int'(tok1_reg.feat) == IDX)
        begin
            res_next.vld = 1'b1;
            if (!vld1_reg)
            begin
                res_next.value = '0;
            end
            else if (tok1_reg.op == ghsa_pkg::OP_RD_SQ)
            begin
                res_next.value = sq_rd_reg;
            end
            else
            begin
                res_next.value = sum_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            tok1_reg  <= '0;
            tok2_reg  <= '0;
            res_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
            res_reg  <= res_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // stores and the multiply pipeline
    always_ff @(posedge clk)
    begin
        sum_rd_reg <= sum_mem[rd_addr];
        sq_rd_reg  <= sq_mem[rd_addr];
        vld1_reg   <= valid_reg[rd_addr];
        px1_reg    <= px;
        px2_reg    <= px1_reg;
        pxx2_reg   <= pxx;
        sum2_reg   <= vld1_reg ? sum_rd_reg : '0;
        sq2_reg    <= vld1_reg ? sq_rd_reg : '0;
        if (wr_en)
        begin
            sum_mem[wr_addr] <= sum_new;
            sq_mem[wr_addr]  <= sq_new;
        end
    end

    assign tok_out = tok1_reg;
    assign res_out = res_reg;

endmodule

/* design/gaussian_hmm_stat_accumulator_top.sv */
// Top level of the Gaussian HMM statistics accumulator: decode, state totals, cell chain.
// Index-error reads go straight into the output register; total reads first pass the registered
//   state-total store read, and sum or square-sum reads walk the whole cell chain.
// Pacing: after a load or accumulate the input stalls until the read-modify-write of the per-cell
//   stores is done; reads one at a time, the chain read walking one cell per cycle.
// Reset (rst_n, asynchronous, active low) clears control, valid bits and sets both registers
//   to 16; stores read as zero until written, so no clearing pass is needed.
module gaussian_hmm_stat_accumulator_top #(
    parameter int MAX_STATES   = ghsa_pkg::DEF_MAX_STATES,
    parameter int MAX_FEATURES = ghsa_pkg::DEF_MAX_FEATURES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ghsa_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [ghsa_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ghsa_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ghsa_pkg::out_t                   out_data
);

    localparam int ST_AW     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    // idle cycles after a chain write so a cell's store write lands before the next read
    localparam int CHAIN_GAP = 2;
    localparam int GAP_W     = $clog2(CHAIN_GAP + 1);

    // ---------------------------------------------------------------- configuration
    logic [ghsa_pkg::CFG_W-1:0] features_used_reg;
    logic [ghsa_pkg::CFG_W-1:0] states_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            features_used_reg <= ghsa_pkg::CFG_RESET_USED;
            states_used_reg   <= ghsa_pkg::CFG_RESET_USED;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == ghsa_pkg::REG_FEATURES_USED)
            begin
                features_used_reg <= cfg_wr_data;
            end
            else if (cfg_index == ghsa_pkg::REG_STATES_USED)
            begin
                states_used_reg <= cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------- decode
    logic                      accept;
    logic                      st_ok;
    logic                      ft_ok;
    logic                      is_read;
    logic                      err_rd;
    logic                      tot_add;
    logic                      tot_rd;
    logic [ghsa_pkg::OP_W-1:0] launch_op;

    // register values above the maximum behave as the maximum
    assign st_ok = int'(in_data.state_index) < int'(states_used_reg)
                   && int'(in_data.state_index) < MAX_STATES;
    assign ft_ok = int'(in_data.feature_index) < int'(features_used_reg)
                   && int'(in_data.feature_index) < MAX_FEATURES;

    assign is_read = in_data.action == ghsa_pkg::ACT_RD_TOTAL
                     || in_data.action == ghsa_pkg::ACT_RD_SUM
                     || in_data.action == ghsa_pkg::ACT_RD_SQ;

    assign err_rd  = is_read
                     && (!st_ok || (in_data.action != ghsa_pkg::ACT_RD_TOTAL && !ft_ok));
    assign tot_add = in_data.action == ghsa_pkg::ACT_ACCUM && st_ok;
    assign tot_rd  = in_data.action == ghsa_pkg::ACT_RD_TOTAL && st_ok;

    always_comb
    begin
        launch_op = ghsa_pkg::OP_NONE;
        if (in_data.action == ghsa_pkg::ACT_LOAD)
        begin
            launch_op = ghsa_pkg::OP_LOAD;
        end
        else if (in_data.action == ghsa_pkg::ACT_ACCUM && st_ok)
        begin
            launch_op = ghsa_pkg::OP_ACC;
        end
        else if (in_data.action == ghsa_pkg::ACT_RD_SUM && st_ok && ft_ok)
        begin
            launch_op = ghsa_pkg::OP_RD_SUM;
        end
        else if (in_data.action == ghsa_pkg::ACT_RD_SQ && st_ok && ft_ok)
        begin
            launch_op = ghsa_pkg::OP_RD_SQ;
        end
    end

    // ---------------------------------------------------------------- control
    logic [GAP_W-1:0] gap_cnt_reg;
    logic [GAP_W-1:0] gap_cnt_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic             tot_add_reg;
    logic             tot_rd_reg;
    ghsa_pkg::tok_t   tok_reg;
    ghsa_pkg::tok_t   tok_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    ghsa_pkg::out_t   out_reg;
    ghsa_pkg::out_t   out_next;

    ghsa_pkg::tok_t   chain_tok [MAX_FEATURES+1];
    ghsa_pkg::res_t   chain_res [MAX_FEATURES+1];
    ghsa_pkg::res_t   res_last;

    // a read waits for the output register to drain; results never queue behind it
    assign in_stall = (gap_cnt_reg != '0) || rd_pend_reg || (out_valid_reg && is_read);
    assign accept   = in_valid && !in_stall;
    assign res_last = chain_res[MAX_FEATURES];

    always_comb
    begin
        tok_next       = '0;
        tok_next.op    = accept ? launch_op : ghsa_pkg::OP_NONE;
        tok_next.state = in_data.state_index;
        tok_next.feat  = in_data.feature_index;
        tok_next.value = in_data.feature_value;
        tok_next.post  = in_data.posterior;
    end

    always_comb
    begin
        gap_cnt_next = gap_cnt_reg;
        if (accept && (launch_op == ghsa_pkg::OP_LOAD || launch_op == ghsa_pkg::OP_ACC))
        begin
            gap_cnt_next = GAP_W'(CHAIN_GAP);
        end
        else if (gap_cnt_reg != '0)
        begin
            gap_cnt_next = gap_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        rd_pend_next = rd_pend_reg;
        if (accept && (tot_rd || launch_op == ghsa_pkg::OP_RD_SUM
                       || launch_op == ghsa_pkg::OP_RD_SQ))
        begin
            rd_pend_next = 1'b1;
        end
        else if (tot_rd_reg || res_last.vld)
        begin
            rd_pend_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- state totals
    logic signed [ghsa_pkg::STAT_W-1:0] tot_mem [MAX_STATES];
    logic signed [ghsa_pkg::STAT_W-1:0] tot_rd_data_reg;
    logic                               tot_vld_rd_reg;
    logic [MAX_STATES-1:0]              tot_valid_reg;
    logic signed [ghsa_pkg::STAT_W-1:0] tot_cur;
    logic signed [ghsa_pkg::STAT_W-1:0] tot_new;
    logic [ST_AW-1:0]                   tot_rd_addr;
    logic [ST_AW-1:0]                   tot_wr_addr;

    assign tot_rd_addr = ST_AW'(in_data.state_index);
    assign tot_wr_addr = ST_AW'(tok_reg.state);
    assign tot_cur     = tot_vld_rd_reg ? tot_rd_data_reg : '0;
    assign tot_new     = ghsa_pkg::sat_add(tot_cur, ghsa_pkg::STAT_W'(tok_reg.post));

    always_ff @(posedge clk)
    begin
        tot_rd_data_reg <= tot_mem[tot_rd_addr];
        tot_vld_rd_reg  <= tot_valid_reg[tot_rd_addr];
        if (tot_add_reg)
        begin
            tot_mem[tot_wr_addr] <= tot_new;
        end
    end

    // ---------------------------------------------------------------- output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        priority if (accept && err_rd)
        begin
            out_valid_next       = 1'b1;
            out_next.stat_value  = '0;
            out_next.index_error = 1'b1;
        end
        else if (tot_rd_reg)
        begin
            out_valid_next       = 1'b1;
            out_next.stat_value  = tot_cur;
            out_next.index_error = 1'b0;
        end
        else if (res_last.vld)
        begin
            out_valid_next       = 1'b1;
            out_next.stat_value  = res_last.value;
            out_next.index_error = 1'b0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            tot_add_reg   <= 1'b0;
            tot_rd_reg    <= 1'b0;
            tok_reg       <= '0;
            out_valid_reg <= 1'b0;
            tot_valid_reg <= '0;
        end
        else
        begin
            gap_cnt_reg   <= gap_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            tot_add_reg   <= accept && tot_add;
            tot_rd_reg    <= accept && tot_rd;
            tok_reg       <= tok_next;
            out_valid_reg <= out_valid_next;
            if (tot_add_reg)
            begin
                tot_valid_reg[tot_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------------------------------------------------------- cell chain
    // The token walks one cell per cycle; the result bus follows it in the next cycle and
    // enters the first cell empty.
    assign chain_tok[0] = tok_reg;
    assign chain_res[0] = '0;

    for (genvar f = 0; f < MAX_FEATURES; f++)
    begin : g_cell
        ghsa_cell #(
            .IDX        (f),
            .MAX_STATES (MAX_STATES)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .features_used (features_used_reg),
            .tok_in        (chain_tok[f]),
            .tok_out       (chain_tok[f+1]),
            .res_in        (chain_res[f]),
            .res_out       (chain_res[f+1])
        );
    end

    // ---------------------------------------------------------------- assertions
    // a read token leaving the last cell has its entry on the bus in the next cycle
    a_chain_res_follows : assert property (@(posedge clk) disable iff (!rst_n)
        (chain_tok[MAX_FEATURES].op == ghsa_pkg::OP_RD_SUM
         || chain_tok[MAX_FEATURES].op == ghsa_pkg::OP_RD_SQ) |=> res_last.vld)
        else $error("chain read token left without a result");

    // chain results only arrive for a pending read, into an empty output register
    a_chain_res_pending : assert property (@(posedge clk) disable iff (!rst_n)
        res_last.vld |-> rd_pend_reg && !out_valid_reg)
        else $error("unexpected chain result");

    // total read data lands into an empty output register
    a_total_rd_slot : assert property (@(posedge clk) disable iff (!rst_n)
        tot_rd_reg |-> rd_pend_reg && !out_valid_reg && !res_last.vld)
        else $error("total read collides with output");

    // every store-writing token opens the spacing window
    a_chain_gap : assert property (@(posedge clk) disable iff (!rst_n)
        (tok_reg.op == ghsa_pkg::OP_ACC || tok_reg.op == ghsa_pkg::OP_LOAD)
        |-> gap_cnt_reg == GAP_W'(CHAIN_GAP))
        else $error("chain write launched without spacing");

endmodule
